// File: hw/rtl/kcd_pkg.sv
package kcd_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // one table slot, also used for the item under work
    typedef struct packed {
        logic [31:0] family;
        logic [31:0] role;
        logic [31:0] link_state;
        logic [63:0] session_low;
        logic [63:0] session_high;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // outcome of one slot compare
    typedef struct packed {
        logic key_hit;
        logic data_same;
    } t_cmp;

endpackage

// File: hw/rtl/kcd_ram.sv
module kcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/kcd_cmp.sv
module kcd_cmp
    import kcd_pkg::*;
(
    input  t_entry i_slot,
    input  t_entry i_item,
    output t_cmp   o_cmp
);

    // key and payload compared separately, shared by scan and final check
    always_comb begin
        o_cmp.key_hit   = (i_slot.family == i_item.family) && (i_slot.role == i_item.role);
        o_cmp.data_same = (i_slot.link_state == i_item.link_state)
                       && (i_slot.session_low == i_item.session_low)
                       && (i_slot.session_high == i_item.session_high);
    end

endmodule

// File: hw/rtl/keyed_change_detect_table_unit.sv
// keyed change detect table: a fully associative table of ENTRIES slots, keyed by
// family and role, that raises report when a connection's state word or 128-bit session
// is new or has changed. a matching valid slot wins, else the lowest free slot, else the
// slot under a round-robin victim pointer, which then advances. an action of 1 empties
// the table and zeroes the pointer, and its result carries report and connected at 0.
// one transaction is worked at a time: o_in_ready is high only while the block is idle.
// an observe transaction first puts slot 0 on the read port, then compares the slots in
// order, re-reads the chosen slot and makes one change check; a key match early in the
// scan cuts the compares short. the scan pace is set by the single read port of the slot
// memory, which the sequencer walks one slot a cycle through one shared compare unit.
// the result sits in an output register, so a new transaction may be taken while the
// previous result still waits for i_out_ready; the new one then holds in its last step
// until that register is free. valid bits live in flip-flops and reset clears them at
// once; there is no clearing pass.
module keyed_change_detect_table_unit
    import kcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transaction
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic signed [31:0] i_family,
    input  logic signed [31:0] i_role,
    input  logic [31:0]        i_link_state,
    input  logic [63:0]        i_session_low,
    input  logic [63:0]        i_session_high,
    // result transaction
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_report,
    output logic               o_connected
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FETCH = 5'b00100,
        S_CHECK = 5'b01000,
        S_CLEAR = 5'b10000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // control state
    t_state             r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [IDX_W-1:0]   r_idx, n_idx;          // slot address issued to the memory
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;  // slot whose data is on the read port
    logic               r_cmp_en, n_cmp_en;
    logic               r_have_free, n_have_free;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic [IDX_W-1:0]   r_pick, n_pick;
    logic               r_out_valid, n_out_valid;
    logic               r_report, n_report;
    logic               r_out_conn, n_out_conn;

    // payload of the transaction under work
    t_entry             r_item;
    logic               r_conn;

    logic               accept;
    logic               out_free;
    logic               hit;
    logic               free_here;
    logic               chg;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    t_entry             slot_rd;
    logic [ENTRY_W-1:0] ram_rdata;
    t_cmp               cmp;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // walk the slots while scanning, otherwise hold the chosen slot on the read port
    assign ram_raddr = (r_state == S_SCAN) ? r_idx : r_pick;

    kcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pick),
        .i_wdata (r_item),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_rd = t_entry'(ram_rdata);

    kcd_cmp u_cmp (
        .i_slot (slot_rd),
        .i_item (r_item),
        .o_cmp  (cmp)
    );

    // scan results for the slot currently on the read port
    assign hit       = r_cmp_en && r_valid[r_cmp_idx] && cmp.key_hit;
    assign free_here = r_cmp_en && !r_valid[r_cmp_idx] && !r_have_free;
    // chosen slot was free, or its state or session moved
    assign chg       = !r_valid[r_pick] || !cmp.data_same;
    assign ram_we    = (r_state == S_CHECK) && out_free && chg;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_en    = r_cmp_en;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_pick      = r_pick;
        n_out_valid = r_out_valid;
        n_report    = r_report;
        n_out_conn  = r_out_conn;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action) begin
                        n_valid = '0;
                        n_ptr   = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_idx       = '0;
                        n_cmp_en    = 1'b0;
                        n_have_free = 1'b0;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_cmp_en  = 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + 1'b1;
                end
                if (free_here) begin
                    n_have_free = 1'b1;
                    n_free_idx  = r_cmp_idx;
                end
                priority if (hit) begin
                    n_pick  = r_cmp_idx;
                    n_state = S_FETCH;
                end else if (r_cmp_en && (r_cmp_idx == LAST_IDX)) begin
                    // no key match anywhere: lowest free slot, else round-robin victim
                    priority if (r_have_free) begin
                        n_pick = r_free_idx;
                    end else if (free_here) begin
                        n_pick = r_cmp_idx;
                    end else begin
                        n_pick = r_ptr;
                        n_ptr  = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
                    end
                    n_state = S_FETCH;
                end else begin
                    // keep walking the slots
                    n_state = S_SCAN;
                end
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_report    = chg;
                    n_out_conn  = r_conn;
                    if (chg) begin
                        n_valid[r_pick] = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_report    = 1'b0;
                    n_out_conn  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_ptr       <= '0;
            r_idx       <= '0;
            r_cmp_idx   <= '0;
            r_cmp_en    <= 1'b0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
            r_pick      <= '0;
            r_out_valid <= 1'b0;
            r_report    <= 1'b0;
            r_out_conn  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_ptr       <= n_ptr;
            r_idx       <= n_idx;
            r_cmp_idx   <= n_cmp_idx;
            r_cmp_en    <= n_cmp_en;
            r_have_free <= n_have_free;
            r_free_idx  <= n_free_idx;
            r_pick      <= n_pick;
            r_out_valid <= n_out_valid;
            r_report    <= n_report;
            r_out_conn  <= n_out_conn;
        end
    end

    // capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.family       <= i_family;
            r_item.role         <= i_role;
            r_item.link_state   <= i_link_state;
            r_item.session_low  <= i_session_low;
            r_item.session_high <= i_session_high;
            r_conn              <= (i_session_low != '0) || (i_session_high != '0);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_report    = r_report;
    assign o_connected = r_out_conn;

endmodule

// File: hw/rtl/kcd_checker.sv
module kcd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_action,
    input logic signed [31:0] i_family,
    input logic signed [31:0] i_role,
    input logic [31:0]        i_link_state,
    input logic [63:0]        i_session_low,
    input logic [63:0]        i_session_high,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_report,
    input logic               o_connected
);

    // busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready right after a transaction was taken");

    // a fresh result only comes out of a busy block
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a transaction in work");

    // no result in the cycle right after acceptance
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_report) && $stable(o_connected)))
        else $error("stalled result changed or dropped");

    // waiting input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_action) && $stable(i_family) && $stable(i_role)
             && $stable(i_link_state) && $stable(i_session_low)
             && $stable(i_session_high)))
        else $error("waiting input transaction changed or dropped");

endmodule

bind keyed_change_detect_table_unit kcd_checker u_kcd_checker (.*);

// File: test/tb_keyed_change_detect_table_unit.sv
module tb_keyed_change_detect_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import kcd_pkg::*;

    // action codes carried in i_action
    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // size of the key pool the random part draws from, larger than the table
    localparam int KEY_POOL = 16;
    // random observe transactions after the directed part
    localparam int RANDOM_UPDATES = 800;
    // cycles the result side holds off once, to back up the block
    localparam int HOLD_CYCLES = 300;

    // one input transaction
    typedef struct packed {
        logic        action;
        logic [31:0] family;
        logic [31:0] role;
        logic [31:0] link_state;
        logic [63:0] session_low;
        logic [63:0] session_high;
    } t_conn_update;

    // one result transaction
    typedef struct packed {
        logic report;
        logic connected;
    } t_outcome;

    // dut signals, the inputs all known from time zero
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic               i_action       = ACT_OBSERVE;
    logic signed [31:0] i_family       = '0;
    logic signed [31:0] i_role         = '0;
    logic [31:0]        i_link_state   = '0;
    logic [63:0]        i_session_low  = '0;
    logic [63:0]        i_session_high = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic               o_report;
    logic               o_connected;

    // stimulus and expectations
    t_conn_update update_queue[$];
    t_outcome     outcome_queue[$];
    t_conn_update drive_item;
    int           total_updates;
    int           accepted_count;
    int           result_count;
    int           error_count;

    // mirror of the slot store, used to predict each outcome
    t_entry       slot_mirror [ENTRIES];
    logic         slot_live   [ENTRIES];
    int           victim_mirror;

    // coverage tallies for the summary
    int           clear_count;
    int           eviction_count;
    int           report_count;
    int           unchanged_hit_count;

    // key pool used by the random part, with the last data sent per key
    logic [31:0]  pool_family  [KEY_POOL];
    logic [31:0]  pool_role    [KEY_POOL];
    logic [31:0]  pool_state   [KEY_POOL];
    logic [63:0]  pool_lo      [KEY_POOL];
    logic [63:0]  pool_hi      [KEY_POOL];

    // pressure hold-off on the result side
    int           hold_left;
    bit           hold_done;

    keyed_change_detect_table_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_family       (i_family),
        .i_role         (i_role),
        .i_link_state   (i_link_state),
        .i_session_low  (i_session_low),
        .i_session_high (i_session_high),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_report       (o_report),
        .o_connected    (o_connected)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // both sides run without idling while this window of transactions goes by
    function automatic bit calm_window();
        return accepted_count >= 450 && accepted_count < 600;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void push_update(logic act, logic [31:0] fam, logic [31:0] rol,
                                        logic [31:0] st, logic [63:0] lo, logic [63:0] hi);
        t_conn_update u;
        u.action       = act;
        u.family       = fam;
        u.role         = rol;
        u.link_state   = st;
        u.session_low  = lo;
        u.session_high = hi;
        update_queue.push_back(u);
    endfunction

    // predicts one transaction against the mirror and applies its effect:
    // key hit first, else lowest free slot, else the round-robin victim
    function automatic t_outcome table_outcome(t_conn_update u);
        t_outcome o;
        int       pick;
        int       free_idx;
        bit       hit;
        bit       have_free;
        o.report    = 1'b0;
        o.connected = (u.session_low != '0) || (u.session_high != '0);
        pick        = 0;
        free_idx    = 0;
        hit         = 1'b0;
        have_free   = 1'b0;

        // clear ignores every other field and reports nothing
        if (u.action == ACT_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_mirror[i] = '0;
                slot_live[i]   = 1'b0;
            end
            victim_mirror = 0;
            clear_count++;
            o.connected = 1'b0;
            return o;
        end

        // key compare on raw bits, signedness plays no part
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && slot_mirror[i].family == u.family &&
                slot_mirror[i].role == u.role) begin
                hit  = 1'b1;
                pick = i;
                break;
            end
            if (!have_free && !slot_live[i]) begin
                have_free = 1'b1;
                free_idx  = i;
            end
        end

        if (!hit) begin
            if (have_free) begin
                pick = free_idx;
            end else begin
                // table full: take the victim and advance, wrapping at ENTRIES
                pick          = victim_mirror;
                victim_mirror = (pick + 1) % ENTRIES;
                eviction_count++;
            end
        end

        if (!slot_live[pick] || slot_mirror[pick].link_state != u.link_state ||
            slot_mirror[pick].session_low != u.session_low ||
            slot_mirror[pick].session_high != u.session_high) begin
            slot_mirror[pick].family       = u.family;
            slot_mirror[pick].role         = u.role;
            slot_mirror[pick].link_state   = u.link_state;
            slot_mirror[pick].session_low  = u.session_low;
            slot_mirror[pick].session_high = u.session_high;
            slot_live[pick]                = 1'b1;
            o.report                       = 1'b1;
        end else begin
            // same key, same data: slot left alone
            unchanged_hit_count++;
        end
        return o;
    endfunction

    // one random transaction; span limits how many pool keys are in play
    function automatic void push_random_update(int span);
        int          r;
        int          k;
        logic [63:0] lo;
        logic [63:0] hi;
        r = $urandom_range(99);
        k = $urandom_range(span - 1);

        if (r < 3) begin
            // clear, with junk in the other fields
            push_update(ACT_CLEAR, $urandom(), $urandom(), $urandom(), rand64(), rand64());
            return;
        end
        if (r >= 78 && r < 90) begin
            // key nobody has seen, everything random
            push_update(ACT_OBSERVE, $urandom(), $urandom(), $urandom(), rand64(), rand64());
            return;
        end

        if (r < 33) begin
            // repeat of the last data for this key, no change unless the key is not in the table
        end else if (r < 58) begin
            // state word change only
            pool_state[k] = $urandom_range(1) ? $urandom_range(3) : $urandom();
        end else if (r < 78) begin
            // session change: zero, one half, or both halves
            lo = pool_lo[k];
            hi = pool_hi[k];
            case ($urandom_range(3))
                0: begin
                    lo = '0;
                    hi = '0;
                end
                1: lo = rand64();
                2: hi = rand64();
                default: begin
                    lo = rand64();
                    hi = rand64();
                end
            endcase
            pool_lo[k] = lo;
            pool_hi[k] = hi;
        end else begin
            pool_state[k] = $urandom();
            pool_lo[k]    = rand64();
            pool_hi[k]    = rand64();
        end
        push_update(ACT_OBSERVE, pool_family[k], pool_role[k], pool_state[k],
                    pool_lo[k], pool_hi[k]);
    endfunction

    // driver: presents queued transactions, holds them until accepted,
    // and predicts each one at the edge where it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                outcome_queue.push_back(table_outcome(drive_item));
                accepted_count++;
            end
            // a single assignment to i_in_valid per edge
            if (!(i_in_valid && !o_in_ready)) begin
                if (update_queue.size() != 0 &&
                    (calm_window() || $urandom_range(99) >= 15)) begin
                    drive_item      = update_queue.pop_front();
                    i_in_valid     <= 1'b1;
                    i_action       <= drive_item.action;
                    i_family       <= drive_item.family;
                    i_role         <= drive_item.role;
                    i_link_state   <= drive_item.link_state;
                    i_session_low  <= drive_item.session_low;
                    i_session_high <= drive_item.session_high;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side ready: random stalls, a calm stretch, and one long hold-off
    // while the driver keeps offering so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left    = 0;
            hold_done    = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && accepted_count >= 150) begin
            hold_done    = 1'b1;
            hold_left    = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm_window() || $urandom_range(99) >= 15;
        end
    end

    // monitor: each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (outcome_queue.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing pending, report %0b connected %0b",
                         $realtime, o_report, o_connected);
            end else begin
                want = outcome_queue.pop_front();
                if (want.report) report_count++;
                if (o_report !== want.report) begin
                    error_count++;
                    $display("%0t: report expected %0b actual %0b",
                             $realtime, want.report, o_report);
                end
                if (o_connected !== want.connected) begin
                    error_count++;
                    $display("%0t: connected expected %0b actual %0b",
                             $realtime, want.connected, o_connected);
                end
            end
        end
    end

    // stimulus build, reset, and end of run
    initial begin
        int spans [4];
        spans = '{4, ENTRIES, ENTRIES + 1, KEY_POOL};

        for (int i = 0; i < ENTRIES; i++) begin
            slot_mirror[i] = '0;
            slot_live[i]   = 1'b0;
        end
        victim_mirror = 0;

        // directed: extreme keys, state and session edges
        push_update(ACT_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
        push_update(ACT_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
        push_update(ACT_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, '1, '0, '0);
        push_update(ACT_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, '1, '1, '0);
        push_update(ACT_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, '1, '0, '1);
        push_update(ACT_OBSERVE, 32'hffff_ffff, 32'h0000_0000, '1, '1, '1);
        // fill the rest of the table, then force three evictions
        for (int i = 2; i < ENTRIES + 3; i++) begin
            push_update(ACT_OBSERVE, 32'h1000_0000 + i, i, $urandom(), rand64(), rand64());
        end
        // first key was evicted, comes back as a miss
        push_update(ACT_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
        // clear with every other field at ones, then rebuild from empty
        push_update(ACT_CLEAR, '1, '1, '1, '1, '1);
        push_update(ACT_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
        push_update(ACT_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);

        // key pool: odd keys share the family of their neighbor so that
        // half-matching keys show up
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_family[k] = (k % 2 == 1) ? pool_family[k - 1] : $urandom();
            pool_role[k]   = $urandom();
            pool_state[k]  = $urandom();
            pool_lo[k]     = rand64();
            pool_hi[k]     = rand64();
        end
        pool_family[0] = 32'h8000_0000;
        pool_role[2]   = 32'h7fff_ffff;

        // random part in chunks with more and more keys in play
        for (int c = 0; c < 4; c++) begin
            for (int n = 0; n < RANDOM_UPDATES / 4; n++) begin
                push_random_update(spans[c]);
            end
        end
        total_updates = update_queue.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_updates) @(posedge i_clk);
        while (outcome_queue.size() != 0) @(posedge i_clk);
        // drain time for any stray result
        repeat (2 * ENTRIES + 8) @(posedge i_clk);

        $display("%0d transactions, %0d results: %0d clears, %0d evictions",
                 total_updates, result_count, clear_count, eviction_count);
        $display("%0d changes reported, %0d unchanged key hits",
                 report_count, unchanged_hit_count);
        if (error_count == 0) begin
            $display("tb_keyed_change_detect_table_unit: done, clean");
        end else begin
            $display("tb_keyed_change_detect_table_unit: done, errors");
        end
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_keyed_change_detect_table_unit: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/kcd_pkg.sv
hw/rtl/kcd_ram.sv
hw/rtl/kcd_cmp.sv
hw/rtl/keyed_change_detect_table_unit.sv
hw/rtl/kcd_checker.sv
test/tb_keyed_change_detect_table_unit.sv
